// ===== hdl/vbf_pkg.sv =====
package vbf_pkg;

	localparam int PT_W    = 16;
	localparam int ETA_W   = 12;
	localparam int PHI_W   = 13;
	localparam int MASS_W  = 16;
	localparam int MPAIR_W = 20;
	localparam int GAP_W   = 12;

	localparam int ROT_W  = 28;
	localparam int K_W    = 4;
	localparam int EXP_W  = 40;
	localparam int PROD_W = 57;
	localparam int P_W    = 27;
	localparam int PXY_W  = 20;
	localparam int PZ_W   = 28;
	localparam int SQ_IN_W = 58;
	localparam int SQ_W    = 29;
	localparam int SQC_W   = $clog2(SQ_W + 1);
	localparam int E_W     = SQ_W;
	localparam int SE_W    = E_W + 1;
	localparam int SE2_W   = 2 * SE_W;
	localparam int SX_W    = PXY_W + 1;
	localparam int SX2_W   = 2 * SX_W;
	localparam int SZ_W    = PZ_W + 1;
	localparam int SZ2_W   = 2 * SZ_W;
	localparam int M2D_W   = SE2_W + 1;
	localparam int M2_W    = SQ_IN_W;
	localparam int MPM2_W  = 2 * MPAIR_W;
	localparam int ADDR_W  = 4;

	localparam logic signed [ROT_W-1:0] Q24_PI      = 28'sd52707179;
	localparam logic signed [ROT_W-1:0] Q24_HALF_PI = 28'sd26353589;
	localparam logic [ROT_W-1:0]        Q24_LN2     = 28'd11629080;
	localparam logic [32:0]             INV_K_CIRC  = 33'd39797;
	localparam logic signed [ROT_W-1:0] INV_K_HYP   = 28'sd20258439;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 57'sd8388608;
	localparam int HYP_REPEAT_A = 4;
	localparam int HYP_REPEAT_B = 13;

	localparam logic [PT_W-1:0]    RST_MIN_JET_PT    = 16'd480;
	localparam logic [MPAIR_W-1:0] RST_MIN_PAIR_MASS = 20'd8000;
	localparam logic [GAP_W-1:0]   RST_MIN_ETA_GAP   = 12'd896;
	localparam logic [MPAIR_W-1:0] MASS_SAT          = 20'hFFFFF;

	localparam logic [1:0] REG_MIN_JET_PT    = 2'd0;
	localparam logic [1:0] REG_MIN_PAIR_MASS = 2'd1;
	localparam logic [1:0] REG_MIN_ETA_GAP   = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CIRC,
		ST_HYP,
		ST_EXP,
		ST_MUL,
		ST_ROUND,
		ST_SQ,
		ST_ESUM,
		ST_ESQRT,
		ST_PRD,
		ST_PSUM,
		ST_PSQ,
		ST_PM2,
		ST_PCMP,
		ST_NEXT,
		ST_FSQ,
		ST_FSQRT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [E_W-1:0]   energy;
		logic [PXY_W-1:0] px;
		logic [PXY_W-1:0] py;
		logic [PZ_W-1:0]  pz;
		logic [ETA_W-1:0] eta;
		logic             passes;
	} jet_rec_t;

	function automatic logic [23:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0: atan_q24 = 24'd13176795;
			5'd1: atan_q24 = 24'd7778716;
			5'd2: atan_q24 = 24'd4110060;
			5'd3: atan_q24 = 24'd2086331;
			5'd4: atan_q24 = 24'd1047214;
			5'd5: atan_q24 = 24'd524117;
			5'd6: atan_q24 = 24'd262123;
			5'd7: atan_q24 = 24'd131069;
			default: atan_q24 = 24'd1 << (5'd24 - i);
		endcase
	endfunction

	function automatic logic [23:0] atanh_q24(input logic [4:0] i);
		case (i)
			5'd0: atanh_q24 = 24'd0;
			5'd1: atanh_q24 = 24'd9215828;
			5'd2: atanh_q24 = 24'd4285116;
			5'd3: atanh_q24 = 24'd2108178;
			5'd4: atanh_q24 = 24'd1049945;
			5'd5: atanh_q24 = 24'd524459;
			5'd6: atanh_q24 = 24'd262165;
			5'd7: atanh_q24 = 24'd131075;
			default: atanh_q24 = 24'd1 << (5'd24 - i);
		endcase
	endfunction

endpackage

// ===== hdl/vbf_jet_pair_select.sv =====
// Forward-jet pair selection, one jet per request, one result per event on the jet marked
// last_jet. Each jet is turned into a four-momentum by one circular CORDIC, a ln2 range
// reduction that takes one multiple of ln2 off |eta| per step (at most eleven multiples),
// one hyperbolic CORDIC with its repeated steps and a one-bit-per-cycle square root, and
// is written to a jet memory. A jet that passes the pt minimum is then paired with each
// earlier stored jet that passes it too: the sequencer reads one memory entry per earlier
// jet and takes it through the read, sum, square, mass-square and compare states (only
// read and sum for an earlier jet that fails the pt minimum). The last jet then also takes
// the pair-mass root, and its result waits while the previous result is still held. Jets
// beyond MAX_JETS in an event are ignored except for their last_jet mark. The jet memory
// is never cleared, since only entries written earlier in the same event are read. A
// result is held in an output register, so the next jet is taken while it waits.
module vbf_jet_pair_select #(
	parameter int MAX_JETS     = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vbf_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [vbf_pkg::PT_W-1:0]            jet_pt,
	input  logic signed [vbf_pkg::ETA_W-1:0]    jet_eta,
	input  logic signed [vbf_pkg::PHI_W-1:0]    jet_phi,
	input  logic [vbf_pkg::MASS_W-1:0]          jet_m,
	input  logic                                last_jet,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pair_found,
	output logic [vbf_pkg::GAP_W-1:0]           eta_gap,
	output logic [vbf_pkg::MPAIR_W-1:0]         pair_mass
);
	import vbf_pkg::*;

	localparam int IDX_W = $clog2(MAX_JETS);
	localparam int JC_W  = $clog2(MAX_JETS + 1);
	localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

	state_t state_q, state_d;

	logic [PT_W-1:0]    min_jet_pt_q;
	logic [MPAIR_W-1:0] min_pair_mass_q;
	logic [GAP_W-1:0]   min_eta_gap_q;
	logic [MPM2_W-1:0]  mpm2_q;

	logic [JC_W-1:0]  jet_cnt_q;
	logic             best_valid_q;
	logic [GAP_W-1:0] best_gap_q;
	logic [M2_W-1:0]  best_m2_q;
	logic [IDX_W-1:0] best_first_q;
	logic             out_valid_q;
	logic             found_q;
	logic [GAP_W-1:0] gap_out_q;
	logic [MPAIR_W-1:0] mass_out_q;

	logic [PT_W-1:0]         pt_q;
	logic signed [ETA_W-1:0] eta_q;
	logic [MASS_W-1:0]       mass_q;
	logic                    last_q;
	logic                    flip_q;
	logic [ROT_W-1:0]        red_r_q;
	logic [K_W-1:0]          red_k_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    rep_q;
	logic signed [ROT_W-1:0] cx_q, cy_q, cz_q;
	logic signed [ROT_W-1:0] hx_q, hy_q, hz_q;
	logic signed [EXP_W-1:0] ch_q, sh_q;
	logic signed [PROD_W-1:0] prod_ch_q, prod_sh_q;
	logic [P_W-1:0]          p_q;
	logic signed [PXY_W-1:0] px_q, py_q;
	logic signed [PZ_W-1:0]  pz_q;
	logic                    passes_q;
	logic [2*P_W-1:0]        p2_q;
	logic [2*MASS_W-1:0]     mj2_q;
	logic [E_W-1:0]          ej_q;

	logic [SQ_IN_W-1:0] sq_rad_q;
	logic [SQ_W+1:0]    sq_rem_q;
	logic [SQ_W-1:0]    sq_root_q;
	logic [SQC_W-1:0]   sq_cnt_q;

	jet_rec_t         jet_mem [MAX_JETS];
	jet_rec_t         rd_s1;
	logic [IDX_W-1:0] pi_q;
	logic [SE_W-1:0]  se_q;
	logic signed [SX_W-1:0] sx_q, sy_q;
	logic signed [SZ_W-1:0] sz_q;
	logic [GAP_W-1:0] gap_q;
	logic [SE2_W-1:0] se2_q;
	logic [SX2_W-1:0] sx2_q, sy2_q;
	logic [SZ2_W-1:0] sz2_q;
	logic [M2_W-1:0]  m2_q;

	logic accept, emit_load, cfg_write;
	logic [32:0] cx_full;
	logic signed [ROT_W-1:0] phi_z, cz0;
	logic flip0;
	logic [ETA_W-1:0] eta_abs;
	logic signed [ROT_W-1:0] cxs, cys, catan, hxs, hys, hatanh;
	logic hyp_rep, hyp_done, red_more, circ_done, sq_done, pair_last;
	logic signed [ROT_W:0] hsum, hdiff;
	logic signed [EXP_W-1:0] ep, em;
	logic signed [PROD_W-1:0] pr_ch, pr_sh;
	logic signed [ROT_W-1:0] xr, yr;
	logic [SQ_W+3:0] rem_sh, trial;
	logic signed [ETA_W:0] eta_d;
	logic signed [M2D_W-1:0] m2d;
	logic pair_ok;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign pair_found = found_q;
	assign eta_gap   = gap_out_q;
	assign pair_mass = mass_out_q;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		case (paddr[3:2])
			REG_MIN_JET_PT:    prdata = 32'(min_jet_pt_q);
			REG_MIN_PAIR_MASS: prdata = 32'(min_pair_mass_q);
			REG_MIN_ETA_GAP:   prdata = 32'(min_eta_gap_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_jet_pt_q    <= RST_MIN_JET_PT;
			min_pair_mass_q <= RST_MIN_PAIR_MASS;
			min_eta_gap_q   <= RST_MIN_ETA_GAP;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_MIN_JET_PT:    min_jet_pt_q    <= pwdata[PT_W-1:0];
				REG_MIN_PAIR_MASS: min_pair_mass_q <= pwdata[MPAIR_W-1:0];
				REG_MIN_ETA_GAP:   min_eta_gap_q   <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mpm2_q <= MPM2_W'(min_pair_mass_q) * MPM2_W'(min_pair_mass_q);
	end

	always_comb begin
		cx_full = 33'(jet_pt) * INV_K_CIRC + 33'd128;
		phi_z   = ROT_W'(jet_phi) <<< 14;
		flip0   = 1'b0;
		cz0     = phi_z;
		if (phi_z > Q24_HALF_PI) begin
			cz0   = phi_z - Q24_PI;
			flip0 = 1'b1;
		end else if (phi_z < -Q24_HALF_PI) begin
			cz0   = phi_z + Q24_PI;
			flip0 = 1'b1;
		end
		eta_abs = jet_eta[ETA_W-1] ? ETA_W'(-jet_eta) : ETA_W'(jet_eta);

		red_more  = (red_r_q >= Q24_LN2);
		cxs       = cx_q >>> cnt_q;
		cys       = cy_q >>> cnt_q;
		catan     = ROT_W'(atan_q24(5'(cnt_q)));
		circ_done = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
		hxs       = hx_q >>> cnt_q;
		hys       = hy_q >>> cnt_q;
		hatanh    = ROT_W'(atanh_q24(5'(cnt_q)));
		hyp_rep   = ((cnt_q == CNT_W'(HYP_REPEAT_A)) || (cnt_q == CNT_W'(HYP_REPEAT_B))) && !rep_q;
		hyp_done  = !hyp_rep && (cnt_q == CNT_W'(CORDIC_STEPS));

		hsum  = (ROT_W+1)'(hx_q) + (ROT_W+1)'(hy_q);
		hdiff = (ROT_W+1)'(hx_q) - (ROT_W+1)'(hy_q);
		ep    = EXP_W'(hsum) <<< red_k_q;
		em    = EXP_W'(hdiff) >>> red_k_q;

		pr_ch = (prod_ch_q + ROUND_HALF) >>> 24;
		pr_sh = (prod_sh_q + ROUND_HALF) >>> 24;
		xr    = (cx_q + ROT_W'(128)) >>> 8;
		yr    = (cy_q + ROT_W'(128)) >>> 8;

		rem_sh = {sq_rem_q, sq_rad_q[SQ_IN_W-1 -: 2]};
		trial  = (SQ_W+4)'({sq_root_q, 2'b01});
		sq_done = (sq_cnt_q == SQC_W'(SQ_W));

		eta_d = (ETA_W+1)'($signed(rd_s1.eta)) - (ETA_W+1)'(eta_q);
		m2d   = $signed(M2D_W'(se2_q)) - $signed(M2D_W'(sx2_q))
			- $signed(M2D_W'(sy2_q)) - $signed(M2D_W'(sz2_q));
		pair_last = ((JC_W'(pi_q) + JC_W'(1)) == jet_cnt_q);
		pair_ok = (m2_q >= M2_W'(mpm2_q)) && (gap_q >= min_eta_gap_q)
			&& (!best_valid_q || (gap_q > best_gap_q)
			|| ((gap_q == best_gap_q) && (pi_q < best_first_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (jet_cnt_q < JC_W'(MAX_JETS)) state_d = ST_REDUCE;
					else if (last_jet) state_d = ST_FSQ;
				end
			end
			ST_REDUCE: if (!red_more) state_d = ST_CIRC;
			ST_CIRC:   if (circ_done) state_d = ST_HYP;
			ST_HYP:    if (hyp_done) state_d = ST_EXP;
			ST_EXP:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_SQ;
			ST_SQ:     state_d = ST_ESUM;
			ST_ESUM:   state_d = ST_ESQRT;
			ST_ESQRT: begin
				if (sq_done) begin
					if (passes_q && (jet_cnt_q != '0)) state_d = ST_PRD;
					else state_d = ST_NEXT;
				end
			end
			ST_PRD:  state_d = ST_PSUM;
			ST_PSUM: begin
				if (rd_s1.passes) state_d = ST_PSQ;
				else if (pair_last) state_d = ST_NEXT;
				else state_d = ST_PRD;
			end
			ST_PSQ:  state_d = ST_PM2;
			ST_PM2:  state_d = ST_PCMP;
			ST_PCMP: state_d = pair_last ? ST_NEXT : ST_PRD;
			ST_NEXT: state_d = last_q ? ST_FSQ : ST_IDLE;
			ST_FSQ:  state_d = ST_FSQRT;
			ST_FSQRT: if (sq_done) state_d = ST_EMIT;
			ST_EMIT: if (emit_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jet_cnt_q    <= '0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_NEXT) jet_cnt_q <= jet_cnt_q + JC_W'(1);
			else if (emit_load) jet_cnt_q <= '0;
			if ((state_q == ST_PCMP) && pair_ok) best_valid_q <= 1'b1;
			else if (emit_load) best_valid_q <= 1'b0;
			if (emit_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			found_q    <= best_valid_q;
			gap_out_q  <= best_valid_q ? best_gap_q : '0;
			mass_out_q <= !best_valid_q ? '0
				: (sq_root_q > SQ_W'(MASS_SAT)) ? MASS_SAT : MPAIR_W'(sq_root_q);
		end
		if ((state_q == ST_PCMP) && pair_ok) begin
			best_gap_q   <= gap_q;
			best_m2_q    <= m2_q;
			best_first_q <= pi_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pt_q    <= jet_pt;
					eta_q   <= jet_eta;
					mass_q  <= jet_m;
					last_q  <= last_jet;
					flip_q  <= flip0;
					cx_q    <= ROT_W'(cx_full[32:8]);
					cy_q    <= '0;
					cz_q    <= cz0;
					red_r_q <= {eta_abs, 16'd0};
					red_k_q <= '0;
				end
			end
			ST_REDUCE: begin
				if (red_more) begin
					red_r_q <= red_r_q - Q24_LN2;
					red_k_q <= red_k_q + K_W'(1);
				end else begin
					hx_q  <= INV_K_HYP;
					hy_q  <= '0;
					hz_q  <= $signed(red_r_q);
					cnt_q <= '0;
				end
			end
			ST_CIRC: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - cys;
					cy_q <= cy_q + cxs;
					cz_q <= cz_q - catan;
				end else begin
					cx_q <= cx_q + cys;
					cy_q <= cy_q - cxs;
					cz_q <= cz_q + catan;
				end
				if (circ_done) begin
					cnt_q <= CNT_W'(1);
					rep_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_HYP: begin
				if (hz_q >= 0) begin
					hx_q <= hx_q + hys;
					hy_q <= hy_q + hxs;
					hz_q <= hz_q - hatanh;
				end else begin
					hx_q <= hx_q - hys;
					hy_q <= hy_q - hxs;
					hz_q <= hz_q + hatanh;
				end
				if (hyp_rep) begin
					rep_q <= 1'b1;
				end else begin
					rep_q <= 1'b0;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_EXP: begin
				ch_q <= (ep + em) >>> 1;
				sh_q <= (ep - em) >>> 1;
			end
			ST_MUL: begin
				prod_ch_q <= PROD_W'($signed({1'b0, pt_q})) * PROD_W'(ch_q);
				prod_sh_q <= PROD_W'($signed({1'b0, pt_q})) * PROD_W'(sh_q);
			end
			ST_ROUND: begin
				p_q      <= (pr_ch < 0) ? '0 : P_W'(pr_ch);
				pz_q     <= eta_q[ETA_W-1] ? -PZ_W'(pr_sh) : PZ_W'(pr_sh);
				px_q     <= flip_q ? -PXY_W'(xr) : PXY_W'(xr);
				py_q     <= flip_q ? -PXY_W'(yr) : PXY_W'(yr);
				passes_q <= (pt_q >= min_jet_pt_q);
			end
			ST_SQ: begin
				p2_q  <= (2*P_W)'(p_q) * (2*P_W)'(p_q);
				mj2_q <= (2*MASS_W)'(mass_q) * (2*MASS_W)'(mass_q);
			end
			ST_ESQRT: begin
				if (sq_done) begin
					ej_q <= sq_root_q;
					pi_q <= '0;
				end
			end
			ST_PSUM: begin
				se_q  <= SE_W'(rd_s1.energy) + SE_W'(ej_q);
				sx_q  <= SX_W'($signed(rd_s1.px)) + SX_W'(px_q);
				sy_q  <= SX_W'($signed(rd_s1.py)) + SX_W'(py_q);
				sz_q  <= SZ_W'($signed(rd_s1.pz)) + SZ_W'(pz_q);
				gap_q <= eta_d[ETA_W] ? GAP_W'(-eta_d) : GAP_W'(eta_d);
				if (!rd_s1.passes) pi_q <= pi_q + IDX_W'(1);
			end
			ST_PSQ: begin
				se2_q <= SE2_W'(se_q) * SE2_W'(se_q);
				sx2_q <= SX2_W'(sx_q) * SX2_W'(sx_q);
				sy2_q <= SX2_W'(sy_q) * SX2_W'(sy_q);
				sz2_q <= SZ2_W'(sz_q) * SZ2_W'(sz_q);
			end
			ST_PM2: begin
				m2_q <= (m2d > 0) ? M2_W'(m2d) : '0;
			end
			ST_PCMP: begin
				pi_q <= pi_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ESUM || state_q == ST_FSQ) begin
			sq_rad_q  <= (state_q == ST_ESUM) ? SQ_IN_W'(p2_q) + SQ_IN_W'(mj2_q) : best_m2_q;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sq_cnt_q  <= '0;
		end else if ((state_q == ST_ESQRT || state_q == ST_FSQRT) && !sq_done) begin
			sq_rad_q <= sq_rad_q << 2;
			sq_cnt_q <= sq_cnt_q + SQC_W'(1);
			if (rem_sh >= trial) begin
				sq_rem_q  <= (SQ_W+2)'(rem_sh - trial);
				sq_root_q <= {sq_root_q[SQ_W-2:0], 1'b1};
			end else begin
				sq_rem_q  <= (SQ_W+2)'(rem_sh);
				sq_root_q <= {sq_root_q[SQ_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_ESQRT) && sq_done) begin
			jet_mem[jet_cnt_q[IDX_W-1:0]] <= '{
				energy: sq_root_q,
				px:     px_q,
				py:     py_q,
				pz:     pz_q,
				eta:    eta_q,
				passes: passes_q
			};
		end
		if (state_q == ST_PRD) begin
			rd_s1 <= jet_mem[pi_q];
		end
	end

`ifndef ASSERT_OFF
	a_one_jet_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((jet_cnt_q < JC_W'(MAX_JETS)) || last_jet) |=> !in_ready)
		else $error("second request taken while a jet is in flight");

	a_jet_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		jet_cnt_q <= JC_W'(MAX_JETS))
		else $error("jet count beyond memory depth");

	a_pair_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRD) |-> (JC_W'(pi_q) < jet_cnt_q))
		else $error("pair read at an entry not yet written");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside of event end");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vbf_pkg::*;

	localparam int JET_SLOTS = 32;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 400;
	localparam longint LN2_Q24 = 11629080;
	localparam longint HALF_PI_Q24 = 26353589;
	localparam longint PI_Q24 = 52707179;
	localparam longint CIRC_GAIN_Q16 = 39797;
	localparam longint HYP_GAIN_Q24 = 20258439;

	typedef struct {
		bit found;
		bit [GAP_W-1:0] gap;
		bit [MPAIR_W-1:0] mass;
	} dijet_t;

	typedef struct {
		bit [PT_W-1:0] pt;
		bit [ETA_W-1:0] eta;
		bit [PHI_W-1:0] phi;
		bit [MASS_W-1:0] mass;
		bit last;
		bit known;
		dijet_t res;
	} jet_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [PT_W-1:0] jet_pt;
	logic signed [ETA_W-1:0] jet_eta;
	logic signed [PHI_W-1:0] jet_phi;
	logic [MASS_W-1:0] jet_m;
	logic last_jet;
	logic out_valid, out_ready;
	logic pair_found;
	logic [GAP_W-1:0] eta_gap;
	logic [MPAIR_W-1:0] pair_mass;

	vbf_jet_pair_select dut (.*);

	longint atan_rom[8] = '{13176795, 7778716, 4110060, 2086331,
		1047214, 524117, 262123, 131069};
	longint atanh_rom[8] = '{0, 9215828, 4285116, 2108178,
		1049945, 524459, 262165, 131075};

	bit [15:0] cut_pt;
	bit [19:0] cut_mass;
	bit [11:0] cut_gap;
	longint jet_e[JET_SLOTS], jet_px[JET_SLOTS], jet_py[JET_SLOTS], jet_pz[JET_SLOTS];
	longint jet_eta_s[JET_SLOTS];
	bit jet_ok[JET_SLOTS];
	int n_jets;
	bit sel_valid;
	longint sel_gap, sel_mass, sel_first;

	dijet_t pending_q[$];
	int errors, sent, idle_cycles, ostall;
	bit quiet;

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic longint root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	task automatic hyp_rot(inout longint x, inout longint y, inout longint z, input int i);
		longint xs, ys, ang;
		xs = x >>> i;
		ys = y >>> i;
		ang = i < 8 ? atanh_rom[i] : (longint'(1) << (24 - i));
		if (z >= 0) begin
			x += ys; y += xs; z -= ang;
		end else begin
			x -= ys; y -= xs; z += ang;
		end
	endtask

	task automatic store_jet(input int s, input longint pt, input longint eta,
			input longint phi, input longint m);
		longint x, y, z, xs, ys, ang, a, k, r, hx, hy, hz, ep, em, ch, sh, p, pz;
		bit flip;
		flip = 0;
		x = (pt * CIRC_GAIN_Q16 + 128) >> 8;
		y = 0;
		z = phi * 16384;
		if (z > HALF_PI_Q24) begin
			z -= PI_Q24; flip = 1;
		end else if (z < -HALF_PI_Q24) begin
			z += PI_Q24; flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			ang = i < 8 ? atan_rom[i] : (longint'(1) << (24 - i));
			if (z >= 0) begin
				x -= ys; y += xs; z -= ang;
			end else begin
				x += ys; y -= xs; z += ang;
			end
		end
		x = (x + 128) >>> 8;
		y = (y + 128) >>> 8;
		if (flip) begin
			x = -x; y = -y;
		end
		a = (eta < 0 ? -eta : eta) * 65536;
		k = a / LN2_Q24;
		r = a - k * LN2_Q24;
		hx = HYP_GAIN_Q24; hy = 0; hz = r;
		for (int i = 1; i <= 16; i++) begin
			hyp_rot(hx, hy, hz, i);
			if (i == 4 || i == 13) hyp_rot(hx, hy, hz, i);
		end
		ep = (hx + hy) << k;
		em = (hx - hy) >>> k;
		ch = (ep + em) >>> 1;
		sh = (ep - em) >>> 1;
		p = (pt * ch + (longint'(1) << 23)) >>> 24;
		pz = (pt * sh + (longint'(1) << 23)) >>> 24;
		if (eta < 0) pz = -pz;
		if (p < 0) p = 0;
		jet_px[s] = x;
		jet_py[s] = y;
		jet_pz[s] = pz;
		jet_e[s] = root64(p * p + m * m);
		jet_eta_s[s] = eta;
		jet_ok[s] = pt >= cut_pt;
	endtask

	task automatic try_pair(input int i, input int j);
		longint se, sx, sy, sz, m2, d, m;
		se = jet_e[i] + jet_e[j];
		sx = jet_px[i] + jet_px[j];
		sy = jet_py[i] + jet_py[j];
		sz = jet_pz[i] + jet_pz[j];
		m2 = se * se - sx * sx - sy * sy - sz * sz;
		d = jet_eta_s[i] - jet_eta_s[j];
		if (d < 0) d = -d;
		m = m2 > 0 ? root64(m2) : 0;
		if (m < cut_mass || d < cut_gap) return;
		if (!sel_valid || d > sel_gap || (d == sel_gap && i < sel_first)) begin
			sel_valid = 1;
			sel_gap = d;
			sel_mass = m > 1048575 ? 1048575 : m;
			sel_first = i;
		end
	endtask

	task automatic predict_jet(input jet_row_t r, output bit emits, output dijet_t res);
		int j;
		emits = 0;
		res = '{0, 0, 0};
		if (n_jets < JET_SLOTS) begin
			j = n_jets;
			store_jet(j, r.pt, longint'($signed(r.eta)), longint'($signed(r.phi)), r.mass);
			if (jet_ok[j])
				for (int i = 0; i < j; i++)
					if (jet_ok[i]) try_pair(i, j);
			n_jets++;
		end
		if (r.last) begin
			emits = 1;
			if (sel_valid) res = '{1, sel_gap[GAP_W-1:0], sel_mass[MPAIR_W-1:0]};
			n_jets = 0;
			sel_valid = 0;
			sel_gap = 0;
			sel_mass = 0;
			sel_first = 0;
		end
	endtask

	task automatic send_jet(input jet_row_t r);
		bit emits;
		dijet_t res;
		in_valid <= 1;
		jet_pt <= r.pt;
		jet_eta <= r.eta;
		jet_phi <= r.phi;
		jet_m <= r.mass;
		last_jet <= r.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_jet(r, emits, res);
		if (emits) pending_q.push_back(r.known ? r.res : res);
		sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		case (idx)
			REG_MIN_JET_PT: cut_pt = val[15:0];
			REG_MIN_PAIR_MASS: cut_mass = val[19:0];
			REG_MIN_ETA_GAP: cut_gap = val[11:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic jet_row_t make_jet(input bit noise, input bit last);
		jet_row_t r;
		r.known = 0;
		r.res = '{0, 0, 0};
		r.last = last;
		if (noise) begin
			r.pt = PT_W'($urandom);
			r.eta = ETA_W'($urandom);
			r.phi = PHI_W'($urandom);
			r.mass = MASS_W'($urandom);
		end else begin
			r.pt = PT_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 700)
				: $urandom_range(300, 4000));
			r.eta = ETA_W'($signed($urandom_range(0, 2560)) - 1280);
			r.phi = PHI_W'($signed($urandom_range(0, 6434)) - 3217);
			r.mass = MASS_W'($urandom_range(0, 1000));
		end
		return r;
	endfunction

	task automatic random_events(input int n_items);
		int stop, len;
		bit noise;
		stop = sent + n_items;
		while (sent < stop) begin
			quiet = sent > 620;
			len = $urandom_range(0, 40) == 0 ? $urandom_range(33, 36) : $urandom_range(1, 7);
			noise = $urandom_range(0, 5) == 0;
			for (int i = 0; i < len; i++) send_jet(make_jet(noise, i == len - 1));
		end
	endtask

	jet_row_t directed[] = '{
		'{16'hFFFF, 12'sd0, 13'sd0, 16'd0, 1, 1, '{0, 0, 0}},
		'{16'd0, 12'sh800, 13'sh1000, 16'hFFFF, 0, 0, '{0, 0, 0}},
		'{16'hFFFF, 12'sd2047, 13'sd4095, 16'd0, 1, 0, '{0, 0, 0}},
		'{16'd1600, -12'sd1024, 13'sd1000, 16'd160, 0, 0, '{0, 0, 0}},
		'{16'd1600, 12'sd1024, -13'sd2000, 16'd160, 0, 0, '{0, 0, 0}},
		'{16'd800, 12'sd200, 13'sd3217, 16'd0, 1, 0, '{0, 0, 0}},
		'{16'd2000, -12'sd600, 13'sd100, 16'd50, 0, 0, '{0, 0, 0}},
		'{16'd2000, 12'sd600, -13'sd3000, 16'd50, 0, 0, '{0, 0, 0}},
		'{16'd2000, -12'sd600, 13'sd3000, 16'd50, 1, 0, '{0, 0, 0}},
		'{16'd479, -12'sd1280, -13'sd3217, 16'd0, 0, 0, '{0, 0, 0}},
		'{16'd480, 12'sd1280, 13'sd3217, 16'hFFFF, 0, 0, '{0, 0, 0}},
		'{16'hFFFF, -12'sd1280, -13'sd1, 16'hFFFF, 1, 0, '{0, 0, 0}},
		'{16'hFFFF, 12'sd1280, 13'sd1608, 16'd0, 0, 0, '{0, 0, 0}},
		'{16'hFFFF, 12'sh800, -13'sd1609, 16'd0, 1, 0, '{0, 0, 0}},
		'{16'd0, 12'sd0, 13'sd0, 16'd0, 1, 1, '{0, 0, 0}}
	};

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
			ostall = 0;
		end else if (quiet) begin
			out_ready <= 1;
		end else if (ostall > 0) begin
			out_ready <= 0;
			ostall--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 0;
			ostall = $urandom_range(0, 4);
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		dijet_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result found=%0d gap=%0d mass=%0d", $time,
					pair_found, eta_gap, pair_mass);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (pair_found !== want.found) begin
					$display("%0t: pair_found expected %0d actual %0d", $time, want.found,
						pair_found);
					errors++;
				end
				if (eta_gap !== want.gap) begin
					$display("%0t: eta_gap expected %0d actual %0d", $time, want.gap, eta_gap);
					errors++;
				end
				if (pair_mass !== want.mass) begin
					$display("%0t: pair_mass expected %0d actual %0d", $time, want.mass,
						pair_mass);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; jet_pt = '0; jet_eta = '0; jet_phi = '0; jet_m = '0; last_jet = 0;
		errors = 0; sent = 0; idle_cycles = 0; quiet = 0;
		cut_pt = 480; cut_mass = 8000; cut_gap = 896;
		n_jets = 0; sel_valid = 0; sel_gap = 0; sel_mass = 0; sel_first = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) send_jet(directed[i]);
		random_events(120);
		drain();

		reg_write(REG_MIN_JET_PT, 32'd0);
		reg_write(REG_MIN_PAIR_MASS, 32'd0);
		reg_write(REG_MIN_ETA_GAP, 32'd0);
		random_events(120);
		drain();

		reg_write(REG_MIN_JET_PT, 32'd65535);
		reg_write(REG_MIN_PAIR_MASS, 32'd1048575);
		reg_write(REG_MIN_ETA_GAP, 32'd2560);
		send_jet('{16'hFFFF, -12'sd1280, 13'sd0, 16'hFFFF, 0, 0, '{0, 0, 0}});
		send_jet('{16'hFFFF, 12'sd1280, 13'sd3217, 16'hFFFF, 1, 0, '{0, 0, 0}});
		random_events(60);
		drain();

		reg_write(REG_MIN_JET_PT, $urandom_range(200, 900));
		reg_write(REG_MIN_PAIR_MASS, $urandom_range(1000, 20000));
		reg_write(REG_MIN_ETA_GAP, $urandom_range(100, 1500));
		random_events(180);
		drain();

		reg_write(REG_MIN_JET_PT, 32'd480);
		reg_write(REG_MIN_PAIR_MASS, 32'd8000);
		reg_write(REG_MIN_ETA_GAP, 32'd896);
		random_events(700 - sent);
		drain();

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
